>>> sv/sit_pkg.sv
// Shared constants and types for the segment intersection test unit.
// Depends on nothing; used by the top level, its checker and the testbench.
package sit_pkg;

  localparam int COORD_WIDTH            = 16;
  localparam int QUOTIENT_FRACTION_BITS = 16;
  localparam int MARGIN_WIDTH           = 16;
  localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = 16'd1;

  typedef enum logic [1:0] {
    VERDICT_CROSS    = 2'd0,
    VERDICT_PARALLEL = 2'd1,
    VERDICT_OUTSIDE  = 2'd2
  } verdict_t;

endpackage

>>> sv/segment_intersection_test_unit.sv
// Pipelined 2D segment-segment crossing test with a programmable end margin.
// Depends on sit_pkg for widths, reset values and verdict codes.
// Throughput: one beat per cycle while the output is not stalled; each of the six stages
// holds its own valid bit, so a stalled output fills empty stages before the input side stalls.
// Reset clears all stage valid bits and sets margin to one.
module segment_intersection_test_unit #(
  parameter int COORD_WIDTH            = sit_pkg::COORD_WIDTH,
  parameter int QUOTIENT_FRACTION_BITS = sit_pkg::QUOTIENT_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [sit_pkg::MARGIN_WIDTH-1:0]    cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
  // b_start_x, b_start_y, b_end_x, b_end_y.
  input  logic [8*COORD_WIDTH-1:0]            s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0 up: verdict[1:0], separate[2], zero padding[7:3].
  output logic [7:0]                          m_tdata
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = QUOTIENT_FRACTION_BITS;
  localparam int MW  = sit_pkg::MARGIN_WIDTH;
  localparam int DFW = W + 1;
  localparam int PW  = 2 * DFW;
  localparam int DW  = PW + 1;
  localparam int SW  = DW + F;
  localparam int KW  = ((F > MW) ? F : MW) + 2;
  localparam int TW  = DW + KW;

  logic [MW-1:0] margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= sit_pkg::MARGIN_RESET;
    end else if (cfg_wen) begin
      margin <= cfg_wdata;
    end
  end

  logic [6:1] v;
  logic [7:1] en;

  always_comb begin
    en[7] = m_tready;
    for (int i = 6; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid;
      end
      for (int i = 2; i <= 6; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 1: direction and offset vectors.
  logic signed [W-1:0]   ax, ay, aex, aey, bx, by, bex, bey;
  logic signed [DFW-1:0] dx0, dy0, dx1, dy1, gx, gy;

  assign ax  = s_tdata[0*W +: W];
  assign ay  = s_tdata[1*W +: W];
  assign aex = s_tdata[2*W +: W];
  assign aey = s_tdata[3*W +: W];
  assign bx  = s_tdata[4*W +: W];
  assign by  = s_tdata[5*W +: W];
  assign bex = s_tdata[6*W +: W];
  assign bey = s_tdata[7*W +: W];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx0 <= DFW'(aex) - DFW'(ax);
      dy0 <= DFW'(aey) - DFW'(ay);
      dx1 <= DFW'(bex) - DFW'(bx);
      dy1 <= DFW'(bey) - DFW'(by);
      gx  <= DFW'(bx) - DFW'(ax);
      gy  <= DFW'(by) - DFW'(ay);
    end
  end

  // Stage 2: the six cross products.
  logic signed [PW-1:0] p_dy0dx1, p_dx0dy1, p_dx1gy, p_dy1gx, p_dx0gy, p_dy0gx;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p_dy0dx1 <= dy0 * dx1;
      p_dx0dy1 <= dx0 * dy1;
      p_dx1gy  <= dx1 * gy;
      p_dy1gx  <= dy1 * gx;
      p_dx0gy  <= dx0 * gy;
      p_dy0gx  <= dy0 * gx;
    end
  end

  // Stage 3: determinant and numerators.
  logic signed [DW-1:0] det3, na3, nb3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      det3 <= DW'(p_dy0dx1) - DW'(p_dx0dy1);
      na3  <= DW'(p_dx1gy) - DW'(p_dy1gx);
      nb3  <= DW'(p_dx0gy) - DW'(p_dy0gx);
    end
  end

  // Stage 4: make the determinant positive and scale the numerators.
  logic signed [DW-1:0] det4;
  logic signed [SW-1:0] sa4, sb4;
  logic                 zero4;
  logic                 neg3;
  logic signed [DW-1:0] na3_pos, nb3_pos;

  assign neg3    = det3[DW-1];
  assign na3_pos = neg3 ? -na3 : na3;
  assign nb3_pos = neg3 ? -nb3 : nb3;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      det4  <= neg3 ? -det3 : det3;
      sa4   <= {na3_pos, {F{1'b0}}};
      sb4   <= {nb3_pos, {F{1'b0}}};
      zero4 <= (det3 == '0);
    end
  end

  // Stage 5: bound thresholds as multiples of the determinant.
  logic signed [KW-1:0] klo, khi_raw, khi;
  logic                 lo_incl, hi_incl;

  assign lo_incl = (margin != '0);
  assign klo     = lo_incl ? $signed(KW'(margin)) : -$signed(KW'(1));
  assign khi_raw = $signed(KW'(1) << F) - $signed(KW'(margin)) + $signed(KW'(1));
  assign hi_incl = (khi_raw > 0);
  assign khi     = hi_incl ? khi_raw : khi_raw - $signed(KW'(1));

  logic signed [TW-1:0] tlo5, thi5;
  logic signed [SW-1:0] sa5, sb5;
  logic                 zero5, lo_incl5, hi_incl5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tlo5     <= TW'(klo) * TW'(det4);
      thi5     <= TW'(khi) * TW'(det4);
      sa5      <= sa4;
      sb5      <= sb4;
      zero5    <= zero4;
      lo_incl5 <= lo_incl;
      hi_incl5 <= hi_incl;
    end
  end

  // Stage 6: bound compares and the verdict.
  logic signed [TW-1:0] sa_w, sb_w;
  logic                 ge_lo_a, ge_hi_a, ge_lo_b, ge_hi_b, out_a, out_b;
  sit_pkg::verdict_t    verdict_next, verdict;
  logic                 separate;

  assign sa_w    = TW'(sa5);
  assign sb_w    = TW'(sb5);
  assign ge_lo_a = lo_incl5 ? (sa_w >= tlo5) : (sa_w > tlo5);
  assign ge_hi_a = hi_incl5 ? (sa_w >= thi5) : (sa_w > thi5);
  assign ge_lo_b = lo_incl5 ? (sb_w >= tlo5) : (sb_w > tlo5);
  assign ge_hi_b = hi_incl5 ? (sb_w >= thi5) : (sb_w > thi5);
  assign out_a   = !ge_lo_a || ge_hi_a;
  assign out_b   = !ge_lo_b || ge_hi_b;

  always_comb begin
    if (zero5) begin
      verdict_next = sit_pkg::VERDICT_PARALLEL;
    end else if (out_a || out_b) begin
      verdict_next = sit_pkg::VERDICT_OUTSIDE;
    end else begin
      verdict_next = sit_pkg::VERDICT_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      verdict  <= verdict_next;
      separate <= (verdict_next != sit_pkg::VERDICT_CROSS);
    end
  end

  assign m_tvalid = v[6];
  assign m_tdata  = {5'b0, separate, verdict};

endmodule

>>> sv/segment_intersection_test_unit_chk.sv
// Port-level checker for the segment intersection test unit, bound to the top level.
// Depends on sit_pkg for the verdict codes.
module segment_intersection_test_unit_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output beat changed or vanished.");

  a_separate: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2] == (m_tdata[1:0] != sit_pkg::VERDICT_CROSS))
    else $error("Separate flag disagrees with the verdict.");

  a_padding: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:3] == 5'b0)
    else $error("Output padding bits are not zero.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output beat present right after reset.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled although the output stage is empty.");

endmodule

bind segment_intersection_test_unit segment_intersection_test_unit_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/crossing_verdict_checker.sv
`timescale 1ns / 1ps
// Watches both stream channels and the margin register of the segment crossing test unit,
// predicts the verdict of every accepted pair and compares each result beat against it.
// Depends on sit_pkg for widths, the margin reset value and the verdict codes.
module crossing_verdict_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [sit_pkg::MARGIN_WIDTH-1:0]     cfg_wdata,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [8*sit_pkg::COORD_WIDTH-1:0]    s_tdata,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [7:0]                           m_tdata,
  output int                                   mismatch_count,
  output int                                   awaited_count,
  output int                                   cross_count,
  output int                                   parallel_count,
  output int                                   outside_count
);

  localparam int CW  = sit_pkg::COORD_WIDTH;
  localparam int QFB = sit_pkg::QUOTIENT_FRACTION_BITS;

  logic [sit_pkg::MARGIN_WIDTH-1:0] margin;
  sit_pkg::verdict_t awaited_verdicts [$];

  // The truncated quotient of scaled / d is at least k, for d > 0.
  function automatic bit quotient_at_least(input longint scaled, input longint d,
                                           input longint k);
    if (k >= 1) begin
      return scaled >= k * d;
    end
    return (k - 1) * d < scaled;
  endfunction

  function automatic bit position_outside(input longint n, input longint d,
                                          input longint m);
    longint scaled;
    longint upper;
    scaled = n * (longint'(1) << QFB);
    upper = (longint'(1) << QFB) - m + 1;
    return !quotient_at_least(scaled, d, m) || quotient_at_least(scaled, d, upper);
  endfunction

  function automatic sit_pkg::verdict_t predict_verdict(
      input logic [8*CW-1:0] beat, input logic [sit_pkg::MARGIN_WIDTH-1:0] m);
    longint c [8];
    longint dax, day, dbx, dby, gx, gy, det, na, nb;
    for (int i = 0; i < 8; i++) begin
      c[i] = longint'($signed(beat[CW*i +: CW]));
    end
    dax = c[2] - c[0];
    day = c[3] - c[1];
    dbx = c[6] - c[4];
    dby = c[7] - c[5];
    gx = c[4] - c[0];
    gy = c[5] - c[1];
    det = day * dbx - dax * dby;
    na = dbx * gy - dby * gx;
    nb = dax * gy - day * gx;
    if (det == 0) begin
      return sit_pkg::VERDICT_PARALLEL;
    end
    if (det < 0) begin
      det = -det;
      na = -na;
      nb = -nb;
    end
    if (position_outside(na, det, longint'(m)) || position_outside(nb, det, longint'(m))) begin
      return sit_pkg::VERDICT_OUTSIDE;
    end
    return sit_pkg::VERDICT_CROSS;
  endfunction

  always @(posedge clk) begin
    sit_pkg::verdict_t want;
    if (rst) begin
      margin = sit_pkg::MARGIN_RESET;
      awaited_verdicts.delete();
      mismatch_count = 0;
      cross_count = 0;
      parallel_count = 0;
      outside_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        case (m_tdata[1:0])
          sit_pkg::VERDICT_CROSS:    cross_count++;
          sit_pkg::VERDICT_PARALLEL: parallel_count++;
          sit_pkg::VERDICT_OUTSIDE:  outside_count++;
          default: ;
        endcase
        if (awaited_verdicts.size() == 0) begin
          $error("Result beat with no pair pending: verdict %0d, separate %0d",
                 m_tdata[1:0], m_tdata[2]);
          mismatch_count++;
        end else begin
          want = awaited_verdicts.pop_front();
          if (m_tdata[1:0] != want) begin
            $error("verdict: expected %0d, actual %0d", want, m_tdata[1:0]);
            mismatch_count++;
          end
          if (m_tdata[2] != (want != sit_pkg::VERDICT_CROSS)) begin
            $error("separate: expected %0d, actual %0d",
                   want != sit_pkg::VERDICT_CROSS, m_tdata[2]);
            mismatch_count++;
          end
          if (m_tdata[7:3] != '0) begin
            $error("padding: expected 0, actual %0d", m_tdata[7:3]);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_verdicts.push_back(predict_verdict(s_tdata, margin));
      end
      if (cfg_wen) begin
        margin = cfg_wdata;
      end
    end
    awaited_count = awaited_verdicts.size();
  end

endmodule

>>> tb/segment_intersection_test_unit_test.sv
`timescale 1ns / 1ps
// Top of the segment intersection test unit testbench: clock, reset, pair stimulus,
// margin writes, result back-pressure and the verdict. Depends on sit_pkg, the unit
// itself and crossing_verdict_checker, which does all prediction and comparison.
module segment_intersection_test_unit_test;

  localparam int CW           = sit_pkg::COORD_WIDTH;
  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES       = 10;
  localparam int PHASE_PAIRS  = 103;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_wen = 1'b0;
  logic [sit_pkg::MARGIN_WIDTH-1:0]  cfg_wdata = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [8*CW-1:0]                   s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [7:0]                        m_tdata;

  int mismatch_count, awaited_count, cross_count, parallel_count, outside_count;
  int cycle_count = 0;
  int pairs_sent = 0;
  bit steady = 1'b0;
  int margin_plan [6] = '{0, 65535, 32768, 32767, 1, 16};

  segment_intersection_test_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  crossing_verdict_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .cross_count    (cross_count),
    .parallel_count (parallel_count),
    .outside_count  (outside_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[segment_intersection_test_unit] ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic send_coords(input int ax0, input int ay0, input int ax1, input int ay1,
                             input int bx0, input int by0, input int bx1, input int by1);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {by1[CW-1:0], bx1[CW-1:0], by0[CW-1:0], bx0[CW-1:0],
               ay1[CW-1:0], ax1[CW-1:0], ay0[CW-1:0], ax0[CW-1:0]};
    do @(posedge clk); while (!s_tready);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_margin(input int value);
    settle();
    cfg_wen = 1'b1;
    cfg_wdata = value[sit_pkg::MARGIN_WIDTH-1:0];
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  // Mostly well-formed geometry: crossings built through a point on the first segment,
  // parallel and collinear pairs, and a small grid that hits endpoints exactly.
  task automatic send_random_pair();
    int c [8];
    int kind, f, g0, g1, px, py, wx, wy, dx, dy, k, j;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      for (int i = 0; i < 8; i++) c[i] = int'($urandom_range(0, 65535));
    end else if (kind < 70) begin
      c[0] = span(-16384, 16383);
      c[1] = span(-16384, 16383);
      c[2] = span(-16384, 16383);
      c[3] = span(-16384, 16383);
      f = $urandom_range(0, 256);
      px = c[0] + (c[2] - c[0]) * f / 256;
      py = c[1] + (c[3] - c[1]) * f / 256;
      wx = span(-8000, 8000);
      wy = span(-8000, 8000);
      g0 = $urandom_range(0, 256);
      g1 = $urandom_range(0, 256);
      c[4] = px - wx * g0 / 256;
      c[5] = py - wy * g0 / 256;
      c[6] = px + wx * g1 / 256;
      c[7] = py + wy * g1 / 256;
    end else if (kind < 85) begin
      dx = span(-4000, 4000);
      dy = span(-4000, 4000);
      c[0] = span(-16000, 16000);
      c[1] = span(-16000, 16000);
      c[2] = c[0] + dx;
      c[3] = c[1] + dy;
      if ($urandom_range(0, 1) == 0) begin
        j = span(-3, 3);
        c[4] = c[0] + dx * j;
        c[5] = c[1] + dy * j;
      end else begin
        c[4] = span(-16000, 16000);
        c[5] = span(-16000, 16000);
      end
      k = span(-3, 3);
      c[6] = c[4] + dx * k;
      c[7] = c[5] + dy * k;
    end else begin
      for (int i = 0; i < 8; i++) c[i] = span(-4, 4);
    end
    send_coords(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int margin;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    send_coords(-256, 0, 256, 0, 0, -256, 0, 256);
    send_coords(-256, 0, 256, 0, 0, 256, 0, -256);
    send_coords(0, 0, 256, 0, 0, 256, 256, 256);
    send_coords(0, 0, 512, 0, 256, 0, 768, 0);
    send_coords(100, 100, 100, 100, 0, 0, 256, 256);
    send_coords(0, 0, 0, 0, 0, 0, 0, 0);
    send_coords(0, 0, 256, 0, 512, -256, 512, 256);
    send_coords(0, 0, 256, 0, 0, 0, 0, 256);
    send_coords(0, 0, 256, 0, 256, -256, 256, 256);
    send_coords(0, 0, 512, 0, 256, 256, 256, 0);
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_coords(0, 0, 1024, 0, 512, 256, 512, 512);
    send_coords(0, 0, 256, 0, 257, -256, 257, 256);
    send_coords(0, 0, 1, 1, 0, 1, 1, 0);
    send_coords(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    send_coords(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);

    for (int p = 0; p < PHASES; p++) begin
      margin = (p < 6) ? margin_plan[p] : int'($urandom_range(0, 32768));
      write_margin(margin);
      steady = (p % 4 == 3);
      for (int i = 0; i < PHASE_PAIRS; i++) begin
        if (p == 2 && i == PHASE_PAIRS / 2) begin
          settle();
        end
        send_random_pair();
      end
    end
    steady = 1'b0;
    settle();

    $display("Sent %0d segment pairs over %0d margin settings, including 0, 32768 and 65535.",
             pairs_sent, PHASES + 1);
    $display("Results seen: %0d crossing, %0d parallel, %0d outside.",
             cross_count, parallel_count, outside_count);
    if (mismatch_count == 0) begin
      $display("[segment_intersection_test_unit] OK");
    end else begin
      $display("[segment_intersection_test_unit] ERROR");
    end
    $finish;
  end

endmodule
